// File: src/bved_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bved_pkg;

	// item kinds carried on the input tuser
	localparam logic [1:0] ACT_LOAD = 2'd0;
	localparam logic [1:0] ACT_RUN  = 2'd1;
	localparam logic [1:0] ACT_READ = 2'd2;

	// configuration register indexes
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_OP_MODE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PASS_COUNT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_X_ENABLE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_ENABLE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_Z_ENABLE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z     = 3'd7;

	// register field widths
	localparam int PASS_W   = 8;
	localparam int SIZE_XY_W = 7;
	localparam int SIZE_Z_W = 5;
	localparam int INDEX_W  = 16;

	// operating modes
	localparam logic MODE_DILATE = 1'b0;
	localparam logic MODE_ERODE  = 1'b1;

	// voxel slots visited per voxel: self first, then the six face neighbors
	localparam int SLOT_W = 3;
	localparam logic [SLOT_W-1:0] SLOT_SELF = 3'd0;
	localparam logic [SLOT_W-1:0] SLOT_XM   = 3'd1;
	localparam logic [SLOT_W-1:0] SLOT_XP   = 3'd2;
	localparam logic [SLOT_W-1:0] SLOT_YM   = 3'd3;
	localparam logic [SLOT_W-1:0] SLOT_YP   = 3'd4;
	localparam logic [SLOT_W-1:0] SLOT_ZM   = 3'd5;
	localparam logic [SLOT_W-1:0] SLOT_ZP   = 3'd6;

	typedef struct packed {
		logic x;
		logic y;
		logic z;
	} axis_en_t;

endpackage

`default_nettype wire

// File: src/bved_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bved_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 65536,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

// File: src/bved_nbr.sv
`timescale 1ns / 1ps
`default_nettype none

module bved_nbr
	import bved_pkg::*;
#(
	parameter int AW  = 16,
	parameter int SXW = 7,
	parameter int SYW = 7,
	parameter int SZW = 5,
	parameter int PW  = 13
) (
	input  wire logic [SLOT_W-1:0] slot,
	input  wire logic [AW-1:0]     center,
	input  wire logic [SXW-1:0]    pos_x,
	input  wire logic [SYW-1:0]    pos_y,
	input  wire logic [SZW-1:0]    pos_z,
	input  wire logic [SXW-1:0]    ext_x,
	input  wire logic [SYW-1:0]    ext_y,
	input  wire logic [SZW-1:0]    ext_z,
	input  wire logic [PW-1:0]     plane,
	input  wire axis_en_t          axis_en,
	output logic                   valid,
	output logic [AW-1:0]          addr
);

	logic [AW-1:0] offset;
	logic          subtract;

	// one shared add/subtract forms every neighbor address
	always_comb begin
		offset   = '0;
		subtract = 1'b0;
		valid    = 1'b0;
		case (slot)
			SLOT_SELF: begin
				valid = 1'b1;
			end
			SLOT_XM: begin
				offset   = AW'(1);
				subtract = 1'b1;
				valid    = axis_en.x && (pos_x != '0);
			end
			SLOT_XP: begin
				offset = AW'(1);
				valid  = axis_en.x && ((SXW+1)'(pos_x) + (SXW+1)'(1) < (SXW+1)'(ext_x));
			end
			SLOT_YM: begin
				offset   = AW'(ext_x);
				subtract = 1'b1;
				valid    = axis_en.y && (pos_y != '0);
			end
			SLOT_YP: begin
				offset = AW'(ext_x);
				valid  = axis_en.y && ((SYW+1)'(pos_y) + (SYW+1)'(1) < (SYW+1)'(ext_y));
			end
			SLOT_ZM: begin
				offset   = AW'(plane);
				subtract = 1'b1;
				valid    = axis_en.z && (pos_z != '0);
			end
			SLOT_ZP: begin
				offset = AW'(plane);
				valid  = axis_en.z && ((SZW+1)'(pos_z) + (SZW+1)'(1) < (SZW+1)'(ext_z));
			end
			default: begin
				valid = 1'b0;
			end
		endcase
		addr = subtract ? (center - offset) : (center + offset);
	end

endmodule

`default_nettype wire

// File: src/binary_volume_erode_dilate_core.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  fields (lowest bit first)
// s_*       in         tuser: action[1:0]; tdata: voxel_index[15:0], voxel_value[16]
// m_*       out        tdata: read_value[0], run_done[1]
// cfg_*     in         write enable, register index [2:0], write data [7:0]
//
// a load steps through the plane, total and exec states to done; a read adds one registered ram read
// a run repeats pass_count passes (none if pass_count is 0): each pass
// copies the mask ram into the snapshot ram one voxel a cycle, then walks every voxel
// through the single snapshot read port, one slot (self or neighbor) at a time
// s_tready is high only while the sequencer is idle; one item is in work at a time
// a finished result waits in the output register while the next item is taken
// reset clears control and config; both voxel rams are undefined until loaded

module binary_volume_erode_dilate_core
	import bved_pkg::*;
#(
	parameter int MAX_SIZE_X = 64,
	parameter int MAX_SIZE_Y = 64,
	parameter int MAX_SIZE_Z = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// input item stream
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [23:0]           s_tdata,   // voxel_index[15:0], voxel_value[16]
	input  wire logic [1:0]            s_tuser,   // action[1:0]
	// result item stream
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [7:0]                 m_tdata,   // read_value[0], run_done[1]
	// config write port
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	// storage geometry
	localparam int DEPTH = MAX_SIZE_X * MAX_SIZE_Y * MAX_SIZE_Z;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int TW    = $clog2(DEPTH + 1);
	localparam int PW    = $clog2(MAX_SIZE_X * MAX_SIZE_Y + 1);
	localparam int SXW   = $clog2(MAX_SIZE_X + 1);
	localparam int SYW   = $clog2(MAX_SIZE_Y + 1);
	localparam int SZW   = $clog2(MAX_SIZE_Z + 1);

	// sequencer states
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_PLANE = 4'd1;
	localparam logic [3:0] S_TOTAL = 4'd2;
	localparam logic [3:0] S_EXEC  = 4'd3;
	localparam logic [3:0] S_RWAIT = 4'd4;
	localparam logic [3:0] S_COPY  = 4'd5;
	localparam logic [3:0] S_CWAIT = 4'd6;
	localparam logic [3:0] S_VRD   = 4'd7;
	localparam logic [3:0] S_VEVAL = 4'd8;
	localparam logic [3:0] S_DONE  = 4'd9;

	function automatic int clamp_size(int v, int mx);
		int r;
		r = v;
		if (v < 1) begin
			r = 1;
		end else if (v > mx) begin
			r = mx;
		end
		return r;
	endfunction

	// config registers
	logic                 op_mode_q;
	logic [PASS_W-1:0]    pass_count_q;
	axis_en_t             axis_en_q;
	logic [SIZE_XY_W-1:0] size_x_q;
	logic [SIZE_XY_W-1:0] size_y_q;
	logic [SIZE_Z_W-1:0]  size_z_q;

	// sequencer and item registers
	logic [3:0]         state_q;
	logic [1:0]         action_q;
	logic [INDEX_W-1:0] idx_q;
	logic               val_q;
	logic [SXW-1:0]     sx_q;
	logic [SYW-1:0]     sy_q;
	logic [SZW-1:0]     sz_q;
	logic [PW-1:0]      plane_q;
	logic [TW-1:0]      total_q;
	logic [PASS_W-1:0]  pass_q;
	logic [AW-1:0]      c_q;
	logic [SXW-1:0]     x_q;
	logic [SYW-1:0]     y_q;
	logic [SZW-1:0]     z_q;
	logic [SLOT_W-1:0]  slot_q;
	logic               self_q;
	logic               res_rd_q;
	logic               res_done_q;

	// copy pipeline: mask read issued, snapshot written in the cycle after
	logic               cp_valid_s1;
	logic [AW-1:0]      cp_addr_s1;

	// output register
	logic               out_valid_q;
	logic               out_rd_q;
	logic               out_done_q;

	// ram ports
	logic               mask_wr_en;
	logic [AW-1:0]      mask_wr_addr;
	logic               mask_wr_data;
	logic [AW-1:0]      mask_rd_addr;
	logic               mask_rd_data;
	logic [AW-1:0]      snap_rd_addr;
	logic               snap_rd_data;

	// neighbor address unit
	logic               nbr_valid;
	logic [AW-1:0]      nbr_addr;

	logic               idx_in_range;
	logic               vox_last;
	logic               pass_last;
	logic               want;
	logic               out_free;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b0, out_done_q, out_rd_q};
	assign out_free = !out_valid_q || m_tready;

	assign idx_in_range = (32'(idx_q) < 32'(total_q));
	assign vox_last     = ((TW+1)'(c_q) + (TW+1)'(1) == (TW+1)'(total_q));
	assign pass_last    = (pass_q + PASS_W'(1) == pass_count_q);
	assign want         = !self_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_mode_q    <= MODE_DILATE;
			pass_count_q <= PASS_W'(1);
			axis_en_q    <= '{x: 1'b1, y: 1'b1, z: 1'b1};
			size_x_q     <= SIZE_XY_W'(64);
			size_y_q     <= SIZE_XY_W'(64);
			size_z_q     <= SIZE_Z_W'(16);
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				CFG_OP_MODE:    op_mode_q    <= cfg_wdata[0];
				CFG_PASS_COUNT: pass_count_q <= cfg_wdata[PASS_W-1:0];
				CFG_X_ENABLE:   axis_en_q.x  <= cfg_wdata[0];
				CFG_Y_ENABLE:   axis_en_q.y  <= cfg_wdata[0];
				CFG_Z_ENABLE:   axis_en_q.z  <= cfg_wdata[0];
				CFG_SIZE_X:     size_x_q     <= cfg_wdata[SIZE_XY_W-1:0];
				CFG_SIZE_Y:     size_y_q     <= cfg_wdata[SIZE_XY_W-1:0];
				CFG_SIZE_Z:     size_z_q     <= cfg_wdata[SIZE_Z_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// mask ram: loads and result writes, copy and read-back reads
	always_comb begin
		mask_wr_en   = 1'b0;
		mask_wr_addr = c_q;
		mask_wr_data = want;
		if (state_q == S_EXEC && action_q == ACT_LOAD) begin
			mask_wr_en   = idx_in_range;
			mask_wr_addr = AW'(32'(idx_q));
			mask_wr_data = val_q;
		end else if (state_q == S_VEVAL && slot_q != SLOT_SELF) begin
			// a neighbor holding the opposite value flips this voxel
			mask_wr_en = (snap_rd_data == want);
		end
		mask_rd_addr = (state_q == S_COPY) ? c_q : AW'(32'(idx_q));
		snap_rd_addr = (slot_q == SLOT_SELF) ? c_q : nbr_addr;
	end

	bved_ram #(
		.WIDTH (1),
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mask_ram (
		.clk     (clk),
		.wr_en   (mask_wr_en),
		.wr_addr (mask_wr_addr),
		.wr_data (mask_wr_data),
		.rd_addr (mask_rd_addr),
		.rd_data (mask_rd_data)
	);

	bved_ram #(
		.WIDTH (1),
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_snap_ram (
		.clk     (clk),
		.wr_en   (cp_valid_s1),
		.wr_addr (cp_addr_s1),
		.wr_data (mask_rd_data),
		.rd_addr (snap_rd_addr),
		.rd_data (snap_rd_data)
	);

	bved_nbr #(
		.AW  (AW),
		.SXW (SXW),
		.SYW (SYW),
		.SZW (SZW),
		.PW  (PW)
	) u_nbr (
		.slot    (slot_q),
		.center  (c_q),
		.pos_x   (x_q),
		.pos_y   (y_q),
		.pos_z   (z_q),
		.ext_x   (sx_q),
		.ext_y   (sy_q),
		.ext_z   (sz_q),
		.plane   (plane_q),
		.axis_en (axis_en_q),
		.valid   (nbr_valid),
		.addr    (nbr_addr)
	);

	// copy pipeline stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cp_valid_s1 <= 1'b0;
		end else begin
			cp_valid_s1 <= (state_q == S_COPY);
		end
	end

	always_ff @(posedge clk) begin
		cp_addr_s1 <= c_q;
	end

	// main sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			slot_q      <= SLOT_SELF;
			pass_q      <= '0;
			c_q         <= '0;
			x_q         <= '0;
			y_q         <= '0;
			z_q         <= '0;
		end else begin
			// output register: a new result may replace one taken this cycle
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_PLANE;
					end
				end
				S_PLANE: begin
					state_q <= S_TOTAL;
				end
				S_TOTAL: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					case (action_q)
						ACT_READ: state_q <= S_RWAIT;
						ACT_RUN: begin
							pass_q <= '0;
							c_q    <= '0;
							if (pass_count_q == '0) begin
								state_q <= S_DONE;
							end else begin
								state_q <= S_COPY;
							end
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_RWAIT: begin
					state_q <= S_DONE;
				end
				S_COPY: begin
					if (vox_last) begin
						state_q <= S_CWAIT;
					end else begin
						c_q <= c_q + AW'(1);
					end
				end
				S_CWAIT: begin
					// last snapshot write lands here
					c_q     <= '0;
					x_q     <= '0;
					y_q     <= '0;
					z_q     <= '0;
					slot_q  <= SLOT_SELF;
					state_q <= S_VRD;
				end
				S_VRD: begin
					if (nbr_valid) begin
						state_q <= S_VEVAL;
					end else if (slot_q == SLOT_ZP) begin
						slot_q <= SLOT_SELF;
						if (vox_last) begin
							pass_q <= pass_q + PASS_W'(1);
							c_q    <= '0;
							state_q <= pass_last ? S_DONE : S_COPY;
						end else begin
							c_q <= c_q + AW'(1);
							if ((SXW+1)'(x_q) + (SXW+1)'(1) == (SXW+1)'(sx_q)) begin
								x_q <= '0;
								if ((SYW+1)'(y_q) + (SYW+1)'(1) == (SYW+1)'(sy_q)) begin
									y_q <= '0;
									z_q <= z_q + SZW'(1);
								end else begin
									y_q <= y_q + SYW'(1);
								end
							end else begin
								x_q <= x_q + SXW'(1);
							end
						end
					end else begin
						slot_q <= slot_q + SLOT_W'(1);
					end
				end
				S_VEVAL: begin
					if (slot_q == SLOT_SELF) begin
						self_q <= snap_rd_data;
					end
					// voxel finished: already in target state, hit found, or slots used up
					if ((slot_q == SLOT_SELF &&
					     ((op_mode_q == MODE_DILATE && snap_rd_data) ||
					      (op_mode_q == MODE_ERODE && !snap_rd_data))) ||
					    (slot_q != SLOT_SELF && snap_rd_data == want) ||
					    (slot_q == SLOT_ZP)) begin
						slot_q <= SLOT_SELF;
						if (vox_last) begin
							pass_q  <= pass_q + PASS_W'(1);
							c_q     <= '0;
							state_q <= pass_last ? S_DONE : S_COPY;
						end else begin
							c_q     <= c_q + AW'(1);
							state_q <= S_VRD;
							if ((SXW+1)'(x_q) + (SXW+1)'(1) == (SXW+1)'(sx_q)) begin
								x_q <= '0;
								if ((SYW+1)'(y_q) + (SYW+1)'(1) == (SYW+1)'(sy_q)) begin
									y_q <= '0;
									z_q <= z_q + SZW'(1);
								end else begin
									y_q <= y_q + SYW'(1);
								end
							end else begin
								x_q <= x_q + SXW'(1);
							end
						end
					end else begin
						slot_q  <= slot_q + SLOT_W'(1);
						state_q <= S_VRD;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item payload, sizes and result fields
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_tvalid) begin
			action_q <= s_tuser;
			idx_q    <= s_tdata[INDEX_W-1:0];
			val_q    <= s_tdata[INDEX_W];
		end
		if (state_q == S_PLANE) begin
			sx_q    <= SXW'(clamp_size(int'(size_x_q), MAX_SIZE_X));
			sy_q    <= SYW'(clamp_size(int'(size_y_q), MAX_SIZE_Y));
			sz_q    <= SZW'(clamp_size(int'(size_z_q), MAX_SIZE_Z));
			plane_q <= PW'(clamp_size(int'(size_x_q), MAX_SIZE_X)) *
			           PW'(clamp_size(int'(size_y_q), MAX_SIZE_Y));
		end
		if (state_q == S_TOTAL) begin
			total_q <= TW'(plane_q) * TW'(sz_q);
		end
		if (state_q == S_EXEC) begin
			res_rd_q   <= 1'b0;
			res_done_q <= (action_q == ACT_RUN);
		end
		if (state_q == S_RWAIT) begin
			res_rd_q <= idx_in_range & mask_rd_data;
		end
		if (state_q == S_DONE && out_free) begin
			out_rd_q   <= res_rd_q;
			out_done_q <= res_done_q;
		end
	end

endmodule

`default_nettype wire
